### rtl/core/llfp_pkg.sv
package llfp_pkg;

    localparam int TS_LEN = 23;
    localparam int POS_W = 5;
    localparam int QDEPTH = 8;
    localparam int QCNT_W = 4;
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_line;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  field_tag;
        logic [7:0]  field_byte;
        logic [1:0]  line_type;
        logic [63:0] unit_id;
        logic        last_of_run;
    } t_result;

    typedef enum logic [3:0] {
        PH_TS    = 4'd0,
        PH_FSM   = 4'd1,
        PH_NAME0 = 4'd2,
        PH_NAME  = 4'd3,
        PH_ID    = 4'd4,
        PH_ARROW = 4'd5,
        PH_SNUM  = 4'd6,
        PH_SNAME = 4'd7,
        PH_PR    = 4'd8,
        PH_PV    = 4'd9,
        PH_MSG   = 4'd10,
        PH_DONE  = 4'd11,
        PH_ERR   = 4'd12
    } t_phase;

    localparam logic       KIND_FIELD   = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [2:0] TAG_TS   = 3'd0;
    localparam logic [2:0] TAG_NAME = 3'd1;
    localparam logic [2:0] TAG_CUR  = 3'd2;
    localparam logic [2:0] TAG_NEW  = 3'd3;
    localparam logic [2:0] TAG_MSG  = 3'd4;

    localparam logic [1:0] LT_MSG     = 2'd0;
    localparam logic [1:0] LT_STATE   = 2'd1;
    localparam logic [1:0] LT_INVALID = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // " FSM: "
    function automatic logic [7:0] fsm_pat(input logic [2:0] idx);
        case (idx)
            3'd0: return CH_SPACE;
            3'd1: return 8'h46;
            3'd2: return 8'h53;
            3'd3: return 8'h4D;
            3'd4: return CH_COLON;
            3'd5: return CH_SPACE;
            default: return 8'h00;
        endcase
    endfunction

    // " id:"
    function automatic logic [7:0] id_pat(input logic [1:0] idx);
        case (idx)
            2'd0: return CH_SPACE;
            2'd1: return 8'h69;
            2'd2: return 8'h64;
            default: return CH_COLON;
        endcase
    endfunction

    // " Pr:"
    function automatic logic [7:0] pr_pat(input logic [1:0] idx);
        case (idx)
            2'd0: return CH_SPACE;
            2'd1: return 8'h50;
            2'd2: return 8'h72;
            default: return CH_COLON;
        endcase
    endfunction

    // " St" after the arrow
    function automatic logic [7:0] arrow_tail(input logic [1:0] idx);
        case (idx)
            2'd0: return CH_SPACE;
            2'd1: return 8'h53;
            2'd2: return 8'h74;
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_result mk_field(input logic [2:0] tag, input logic [7:0] b);
        t_result r;
        r = '0;
        r.result_kind = KIND_FIELD;
        r.field_tag   = tag;
        r.field_byte  = b;
        return r;
    endfunction

    function automatic t_result mk_verdict(input logic [1:0] lt, input logic [63:0] id);
        t_result r;
        r = '0;
        r.result_kind = KIND_VERDICT;
        r.line_type   = lt;
        r.unit_id     = id;
        return r;
    endfunction

endpackage

### rtl/core/log_line_field_parser_core.sv
// log line field parser
// input channel: i_valid / o_stall carry one byte of a log line per
// transaction, end_of_line set on the last byte of a nonempty line.
// output channel: o_valid / i_stall carry one result per transaction:
// a tagged field byte (timestamp, machine name, current/new state, message)
// or the line verdict with the parsed machine id.
// an accepted byte is registered in the input register; the parser step
// runs on it while the queue holds at most 4 results and writes its 0 to 4
// results into an 8-entry result queue; the first result reaches the queue
// head and is offered in the cycle after that step if the queue was empty.
// throughput: one byte per cycle while the queue holds at most 4 results;
// a byte that causes k results sends them one by one through the single output
// port, so the output port sets the rate when bytes cause several results.
// reset clears the parser to the start of a line and empties the queue.
// when the receiver stalls, the head result holds, the queue fills and
// o_stall rises once the input register cannot move into the queue.
module log_line_field_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  llfp_pkg::t_item     i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output llfp_pkg::t_result   o_result
);
    import llfp_pkg::*;

    // input register
    logic             r_in_v;
    t_item            r_in;

    // parser state
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_k, n_k;
    logic [1:0]       r_held, n_held;
    logic [63:0]      r_id, n_id;
    logic             r_ovf, n_ovf;
    logic             r_digits_done, n_digits_done;
    logic             r_kind, n_kind;
    logic             r_colon, n_colon;

    // result queue, head at slot 0
    t_result          r_q [QDEPTH];
    t_result          n_q [QDEPTH];
    logic [QCNT_W-1:0] r_cnt;

    t_result          res [MAX_RES];
    logic [2:0]       rn;
    logic [2:0]       kk;
    logic [2:0]       stag;
    logic             ok;
    logic [7:0]       c;
    logic             eol;
    logic             is_digit;
    logic [67:0]      id_next;
    logic             proc;
    logic             pop;
    logic             accept;
    logic [QCNT_W-1:0] keep;
    logic [QCNT_W-1:0] m;

    assign proc   = r_in_v && (r_cnt <= QCNT_W'(QDEPTH - MAX_RES));
    assign o_stall = r_in_v && !proc;
    assign accept = i_valid && !o_stall;
    assign pop    = (r_cnt != '0) && !i_stall;
    assign o_valid = (r_cnt != '0);
    assign o_result = r_q[0];

    assign c   = r_in.data_byte;
    assign eol = r_in.end_of_line;
    assign is_digit = (c inside {[CH_ZERO:CH_NINE]});
    // id * 10 + digit, overflow when anything lands above bit 63
    assign id_next = ({4'b0, r_id} << 3) + ({4'b0, r_id} << 1) + {60'b0, c - CH_ZERO};

    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_k           = r_k;
        n_held        = r_held;
        n_id          = r_id;
        n_ovf         = r_ovf;
        n_digits_done = r_digits_done;
        n_kind        = r_kind;
        n_colon       = r_colon;
        rn            = 3'd0;
        ok            = 1'b0;
        kk            = r_k;
        stag          = r_kind ? TAG_NEW : TAG_CUR;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end

        case (r_phase)
            PH_TS: begin
                res[rn[1:0]] = mk_field(TAG_TS, c);
                rn = rn + 3'd1;
                if ({1'b0, r_pos} + 6'd1 >= 6'(TS_LEN)) begin
                    n_phase = PH_FSM;
                    n_k     = 3'd0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            PH_FSM: begin
                if (kk > 3'd5) kk = 3'd0;
                if (c == fsm_pat(kk)) kk = kk + 3'd1;
                else kk = (c == CH_SPACE) ? 3'd1 : 3'd0;
                if (kk == 3'd6) begin
                    n_phase = PH_NAME0;
                    kk      = 3'd0;
                end
                n_k = kk;
            end
            PH_NAME0: begin
                res[rn[1:0]] = mk_field(TAG_NAME, c);
                rn = rn + 3'd1;
                n_phase = PH_NAME;
                n_k     = 3'd0;
                n_held  = 2'd0;
            end
            PH_NAME: begin
                if (eol) begin
                    n_phase = PH_ERR;
                end else begin
                    if (kk > 3'd3) kk = 3'd0;
                    if (c == id_pat(kk[1:0])) begin
                        if (kk == 3'd3) begin
                            n_phase = PH_ID;
                            n_k     = 3'd0;
                            n_held  = 2'd0;
                        end else begin
                            n_k    = kk + 3'd1;
                            n_held = 2'(kk + 3'd1);
                        end
                    end else begin
                        // flush the partial " id:" match as name bytes
                        for (int i = 0; i < 3; i++) begin
                            if (3'(i) < kk) begin
                                res[rn[1:0]] = mk_field(TAG_NAME, id_pat(2'(i)));
                                rn = rn + 3'd1;
                            end
                        end
                        if (c == CH_SPACE) begin
                            n_k    = 3'd1;
                            n_held = 2'd1;
                        end else begin
                            res[rn[1:0]] = mk_field(TAG_NAME, c);
                            rn = rn + 3'd1;
                            n_k    = 3'd0;
                            n_held = 2'd0;
                        end
                    end
                end
            end
            PH_ID: begin
                if (r_k == 3'd0 && c == CH_SPACE) begin
                    // leading spaces
                end else if (r_k == 3'd0 && c == CH_SEMI) begin
                    n_phase = PH_ERR;
                end else begin
                    n_k = 3'd1;
                    if (c == CH_SEMI) begin
                        n_phase = PH_ARROW;
                        n_k     = 3'd0;
                    end else if (!r_digits_done && is_digit) begin
                        if (!r_ovf) begin
                            if (id_next[67:64] != 4'd0) n_ovf = 1'b1;
                            else n_id = id_next[63:0];
                        end
                    end else begin
                        n_digits_done = 1'b1;
                    end
                end
            end
            PH_ARROW: begin
                if (r_k == 3'd0) begin
                    if (c == CH_SPACE) begin
                        // skip
                    end else if (c == CH_GT) begin
                        n_kind = 1'b0;
                        n_k    = 3'd1;
                    end else if (c == CH_LT) begin
                        n_kind = 1'b1;
                        n_k    = 3'd1;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end else if (r_k <= 3'd3 && c == arrow_tail(2'(r_k - 3'd1))) begin
                    if (r_k == 3'd3) begin
                        n_phase = PH_SNUM;
                        n_k     = 3'd0;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_SNUM: begin
                if (r_k == 3'd0 && c == CH_COLON) begin
                    n_k = 3'd1;
                end else if (r_k == 3'd1) begin
                    if (c == CH_SPACE) begin
                        n_k = 3'd2;
                    end else begin
                        // colon not followed by space starts the name
                        res[rn[1:0]] = mk_field(stag, CH_COLON);
                        rn = rn + 3'd1;
                        res[rn[1:0]] = mk_field(stag, c);
                        rn = rn + 3'd1;
                        n_phase = PH_SNAME;
                        n_k     = 3'd0;
                    end
                end else if (r_k <= 3'd2 && is_digit) begin
                    n_k = 3'd2;
                end else if (c == CH_SPACE) begin
                    n_k = 3'd3;
                end else begin
                    res[rn[1:0]] = mk_field(stag, c);
                    rn = rn + 3'd1;
                    n_phase = PH_SNAME;
                    n_k     = 3'd0;
                end
            end
            PH_SNAME: begin
                if (c == CH_SPACE) begin
                    if (r_kind) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PR;
                        n_k     = 3'd1;
                    end
                end else begin
                    res[rn[1:0]] = mk_field(stag, c);
                    rn = rn + 3'd1;
                end
            end
            PH_PR: begin
                if (kk > 3'd3) kk = 3'd0;
                if (c == pr_pat(kk[1:0])) kk = kk + 3'd1;
                else kk = (c == CH_SPACE) ? 3'd1 : 3'd0;
                if (kk == 3'd4) begin
                    n_phase = PH_PV;
                    kk      = 3'd0;
                    n_colon = 1'b0;
                end
                n_k = kk;
            end
            PH_PV: begin
                if (r_k == 3'd0) begin
                    if (c != CH_SPACE) begin
                        n_k     = 3'd1;
                        n_colon = (c == CH_COLON);
                    end
                end else if (c == CH_SPACE) begin
                    if (r_colon) begin
                        n_phase = PH_MSG;
                        n_k     = 3'd0;
                        n_held  = 2'd0;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end else if (c == CH_COLON) begin
                    n_colon = 1'b1;
                end
            end
            PH_MSG: begin
                if (r_k == 3'd0) begin
                    if (c != CH_SPACE) begin
                        res[rn[1:0]] = mk_field(TAG_MSG, c);
                        rn = rn + 3'd1;
                        n_k    = 3'd1;
                        n_held = 2'd0;
                    end
                end else if (r_held != 2'd0) begin
                    // a space is pending: " (" closes the text
                    if (c == CH_LPAREN) begin
                        n_phase = PH_DONE;
                        n_held  = 2'd0;
                    end else if (c == CH_SPACE) begin
                        res[rn[1:0]] = mk_field(TAG_MSG, CH_SPACE);
                        rn = rn + 3'd1;
                    end else begin
                        res[rn[1:0]] = mk_field(TAG_MSG, CH_SPACE);
                        rn = rn + 3'd1;
                        res[rn[1:0]] = mk_field(TAG_MSG, c);
                        rn = rn + 3'd1;
                        n_held = 2'd0;
                    end
                end else if (c == CH_SPACE) begin
                    n_held = 2'd1;
                end else begin
                    res[rn[1:0]] = mk_field(TAG_MSG, c);
                    rn = rn + 3'd1;
                end
            end
            default: begin
                // done, failed and unused codes ignore the byte
            end
        endcase

        if (eol) begin
            case (n_phase)
                PH_DONE: ok = 1'b1;
                PH_SNUM: begin
                    if (n_k == 3'd1) begin
                        res[rn[1:0]] = mk_field(stag, CH_COLON);
                        rn = rn + 3'd1;
                    end
                    ok = n_kind;
                end
                PH_SNAME: ok = n_kind;
                PH_PV:    ok = (n_k == 3'd1) && n_colon;
                PH_MSG: begin
                    if (n_held != 2'd0) begin
                        res[rn[1:0]] = mk_field(TAG_MSG, CH_SPACE);
                        rn = rn + 3'd1;
                    end
                    ok = 1'b1;
                end
                default: ok = 1'b0;
            endcase
            res[rn[1:0]] = mk_verdict(ok ? (n_kind ? LT_STATE : LT_MSG) : LT_INVALID,
                                      (ok && !n_ovf) ? n_id : 64'd0);
            rn = rn + 3'd1;
            n_phase       = PH_TS;
            n_pos         = '0;
            n_k           = 3'd0;
            n_held        = 2'd0;
            n_id          = 64'd0;
            n_ovf         = 1'b0;
            n_digits_done = 1'b0;
            n_kind        = 1'b0;
            n_colon       = 1'b0;
        end

        if (rn != 3'd0) begin
            res[2'(rn - 3'd1)].last_of_run = 1'b1;
        end
    end

    // queue: shift down on pop, append new results behind the survivors
    always_comb begin
        keep = r_cnt - {{(QCNT_W-1){1'b0}}, pop};
        m    = '0;
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
            if (QCNT_W'(i) < keep) begin
                n_q[i] = pop ? r_q[(i == QDEPTH-1) ? i : i+1] : r_q[i];
            end else begin
                m = QCNT_W'(i) - keep;
                if (proc && m < {1'b0, rn}) begin
                    n_q[i] = res[m[1:0]];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v        <= 1'b0;
            r_cnt         <= '0;
            r_phase       <= PH_TS;
            r_pos         <= '0;
            r_k           <= 3'd0;
            r_held        <= 2'd0;
            r_id          <= 64'd0;
            r_ovf         <= 1'b0;
            r_digits_done <= 1'b0;
            r_kind        <= 1'b0;
            r_colon       <= 1'b0;
        end else begin
            if (accept) begin
                r_in_v <= 1'b1;
            end else if (proc) begin
                r_in_v <= 1'b0;
            end
            r_cnt <= keep + (proc ? {1'b0, rn} : '0);
            if (proc) begin
                r_phase       <= n_phase;
                r_pos         <= n_pos;
                r_k           <= n_k;
                r_held        <= n_held;
                r_id          <= n_id;
                r_ovf         <= n_ovf;
                r_digits_done <= n_digits_done;
                r_kind        <= n_kind;
                r_colon       <= n_colon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

### sim/tb_log_line_field_parser_core.sv
module tb_log_line_field_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import llfp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_A      = 40;
    localparam int HOLD_B      = 160;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 30;

    localparam logic [47:0] SEQ_FSM  = " FSM: ";
    localparam logic [47:0] SEQ_ID   = {16'h0, " id:"};
    localparam logic [47:0] SEQ_PR   = {16'h0, " Pr:"};
    localparam logic [47:0] SEQ_TAIL = {24'h0, " St"};
    localparam logic [63:0] ID_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_item      it;
        logic [3:0] gap;
        logic       pause;
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_item     i_item = '0;
    logic      o_stall;
    logic      o_valid;
    t_result   o_result;

    log_line_field_parser_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // parser state mirrored by the predictor
    t_phase           ph;
    logic [POS_W-1:0] pos;
    logic [2:0]       mp;
    logic [7:0]       held [0:2];
    logic [1:0]       hcnt;
    logic [63:0]      idv;
    logic             idovf;
    logic             iddone;
    logic             lkind;
    logic             colon;

    t_result run_buf [0:5];
    int      run_n;
    t_result parse_out_q [$];

    logic [7:0] line_q [$];
    t_stim      byte_q [$];

    int errors = 0;
    int res_count = 0;
    int field_count = 0;
    int n_msg = 0, n_state = 0, n_invalid = 0;
    int lines_built = 0, bytes_built = 0;
    int cycles = 0;

    logic  in_fire = 1'b0;
    logic  out_fire = 1'b0;
    t_stim cur;
    int    gap_left = 0;
    bit    gap_loaded = 0;
    int    stall_left = 0;
    int    rmax = 0;
    t_result want;

    task automatic clear_line();
        ph     = PH_TS;
        pos    = '0;
        mp     = '0;
        hcnt   = '0;
        idv    = '0;
        idovf  = 1'b0;
        iddone = 1'b0;
        lkind  = 1'b0;
        colon  = 1'b0;
    endtask

    function automatic logic [7:0] seq_byte(logic [47:0] s, int len, logic [2:0] k);
        return s[8*(len-1-int'(k)) +: 8];
    endfunction

    // searches start with a space, so a stray space restarts the match at one
    function automatic logic [2:0] seek_next(logic [47:0] s, int len, logic [2:0] k,
                                             logic [7:0] c);
        if (c == seq_byte(s, len, k)) return k + 3'd1;
        return (c == CH_SPACE) ? 3'd1 : 3'd0;
    endfunction

    task automatic emit_field(logic [2:0] tag, logic [7:0] b);
        t_result r;
        r = '0;
        r.result_kind = KIND_FIELD;
        r.field_tag   = tag;
        r.field_byte  = b;
        run_buf[run_n] = r;
        run_n++;
    endtask

    task automatic emit_verdict(logic [1:0] lt, logic [63:0] id);
        t_result r;
        r = '0;
        r.result_kind = KIND_VERDICT;
        r.line_type   = lt;
        r.unit_id     = id;
        run_buf[run_n] = r;
        run_n++;
    endtask

    task automatic parse_byte(input t_item it);
        logic [7:0]  c;
        logic        eol;
        logic [2:0]  k;
        logic [2:0]  stag;
        logic        ok;
        logic [63:0] d;
        t_result     r;
        int          i;
        c     = it.data_byte;
        eol   = it.end_of_line;
        run_n = 0;
        stag  = lkind ? TAG_NEW : TAG_CUR;
        k     = mp;
        case (ph)
            PH_TS: begin
                emit_field(TAG_TS, c);
                if (int'(pos) + 1 >= TS_LEN) begin
                    ph = PH_FSM;
                    mp = '0;
                end else begin
                    pos = pos + 1'b1;
                end
            end
            PH_FSM: begin
                if (k > 5) k = 3'd0;
                k = seek_next(SEQ_FSM, 6, k, c);
                if (k == 6) begin
                    ph = PH_NAME0;
                    k = 3'd0;
                end
                mp = k;
            end
            PH_NAME0: begin
                emit_field(TAG_NAME, c);
                ph   = PH_NAME;
                mp   = '0;
                hcnt = '0;
            end
            PH_NAME: begin
                if (eol) begin
                    ph = PH_ERR;
                end else begin
                    if (k > 3) k = 3'd0;
                    if (c == seq_byte(SEQ_ID, 4, k)) begin
                        if (k == 3) begin
                            ph   = PH_ID;
                            mp   = '0;
                            hcnt = '0;
                        end else begin
                            held[k] = c;
                            k = k + 3'd1;
                            mp = k;
                            hcnt = k[1:0];
                        end
                    end else begin
                        // partial " id:" turned out to be name text
                        for (i = 0; i < k; i++) emit_field(TAG_NAME, held[i]);
                        if (c == CH_SPACE) begin
                            held[0] = CH_SPACE;
                            k = 3'd1;
                        end else begin
                            emit_field(TAG_NAME, c);
                            k = 3'd0;
                        end
                        mp = k;
                        hcnt = k[1:0];
                    end
                end
            end
            PH_ID: begin
                if (k == 0 && c == CH_SPACE) begin
                end else if (k == 0 && c == CH_SEMI) begin
                    ph = PH_ERR;
                end else begin
                    if (k == 0) mp = 3'd1;
                    if (c == CH_SEMI) begin
                        ph = PH_ARROW;
                        mp = '0;
                    end else if (!iddone && c >= CH_ZERO && c <= CH_NINE) begin
                        d = {56'd0, c - CH_ZERO};
                        if (!idovf) begin
                            if (idv > (ID_MAX - d) / 64'd10) idovf = 1'b1;
                            else idv = idv * 64'd10 + d;
                        end
                    end else begin
                        iddone = 1'b1;
                    end
                end
            end
            PH_ARROW: begin
                if (k == 0) begin
                    if (c == CH_SPACE) begin
                    end else if (c == CH_GT) begin
                        lkind = 1'b0;
                        mp = 3'd1;
                    end else if (c == CH_LT) begin
                        lkind = 1'b1;
                        mp = 3'd1;
                    end else begin
                        ph = PH_ERR;
                    end
                end else if (k <= 3 && c == seq_byte(SEQ_TAIL, 3, k - 3'd1)) begin
                    k = k + 3'd1;
                    if (k == 4) begin
                        ph = PH_SNUM;
                        k = 3'd0;
                    end
                    mp = k;
                end else begin
                    ph = PH_ERR;
                end
            end
            PH_SNUM: begin
                if (k == 0 && c == CH_COLON) begin
                    mp = 3'd1;
                end else if (k == 1 && c == CH_SPACE) begin
                    mp = 3'd2;
                end else if (k != 1 && k <= 2 && c >= CH_ZERO && c <= CH_NINE) begin
                    mp = 3'd2;
                end else if (k != 1 && c == CH_SPACE) begin
                    mp = 3'd3;
                end else begin
                    // a colon not followed by a space starts the state name
                    if (k == 1) emit_field(stag, CH_COLON);
                    emit_field(stag, c);
                    ph = PH_SNAME;
                    mp = '0;
                end
            end
            PH_SNAME: begin
                if (c == CH_SPACE) begin
                    if (lkind) begin
                        ph = PH_DONE;
                    end else begin
                        ph = PH_PR;
                        mp = 3'd1;
                    end
                end else begin
                    emit_field(stag, c);
                end
            end
            PH_PR: begin
                if (k > 3) k = 3'd0;
                k = seek_next(SEQ_PR, 4, k, c);
                if (k == 4) begin
                    ph = PH_PV;
                    k = 3'd0;
                    colon = 1'b0;
                end
                mp = k;
            end
            PH_PV: begin
                if (k == 0) begin
                    if (c != CH_SPACE) begin
                        mp = 3'd1;
                        colon = (c == CH_COLON);
                    end
                end else if (c == CH_SPACE) begin
                    if (colon) begin
                        ph   = PH_MSG;
                        mp   = '0;
                        hcnt = '0;
                    end else begin
                        ph = PH_ERR;
                    end
                end else if (c == CH_COLON) begin
                    colon = 1'b1;
                end
            end
            PH_MSG: begin
                if (k == 0) begin
                    if (c != CH_SPACE) begin
                        emit_field(TAG_MSG, c);
                        mp = 3'd1;
                        hcnt = '0;
                    end
                end else if (hcnt != 0) begin
                    // one space held back in case " (" closes the text
                    if (c == CH_LPAREN) begin
                        ph = PH_DONE;
                        hcnt = '0;
                    end else if (c == CH_SPACE) begin
                        emit_field(TAG_MSG, CH_SPACE);
                    end else begin
                        emit_field(TAG_MSG, CH_SPACE);
                        emit_field(TAG_MSG, c);
                        hcnt = '0;
                    end
                end else if (c == CH_SPACE) begin
                    held[0] = CH_SPACE;
                    hcnt = 2'd1;
                end else begin
                    emit_field(TAG_MSG, c);
                end
            end
            default: begin
            end
        endcase

        if (eol) begin
            ok = 1'b0;
            case (ph)
                PH_DONE:  ok = 1'b1;
                PH_SNUM: begin
                    if (mp == 1) emit_field(stag, CH_COLON);
                    ok = lkind;
                end
                PH_SNAME: ok = lkind;
                PH_PV:    ok = (mp == 1) && colon;
                PH_MSG: begin
                    if (hcnt != 0) emit_field(TAG_MSG, CH_SPACE);
                    ok = 1'b1;
                end
                default:  ok = 1'b0;
            endcase
            emit_verdict(ok ? (lkind ? LT_STATE : LT_MSG) : LT_INVALID,
                         (ok && !idovf) ? idv : 64'd0);
            clear_line();
        end

        for (i = 0; i < run_n; i++) begin
            r = run_buf[i];
            r.last_of_run = (i == run_n - 1);
            parse_out_q.push_back(r);
        end
    endtask

    task automatic add_str(string s);
        int i;
        for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic add_pick(string alpha, int n);
        repeat (n) line_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
    endtask

    task automatic add_ts();
        repeat (TS_LEN) line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_line(bit pause);
        t_stim st;
        int    gmax;
        int    i;
        gmax = ($urandom_range(0, 2) == 0) ? 0 : 12;
        for (i = 0; i < line_q.size(); i++) begin
            st.it.data_byte   = line_q[i];
            st.it.end_of_line = (i == line_q.size() - 1);
            st.gap            = 4'($urandom_range(0, gmax));
            st.pause          = pause && (i == 0);
            byte_q.push_back(st);
        end
        lines_built++;
        bytes_built += line_q.size();
    endtask

    task automatic queue_line_text(string s, bit pause);
        line_q.delete();
        add_ts();
        add_str(s);
        send_line(pause);
    endtask

    task automatic make_random_line();
        int  n;
        bit  state_line;
        line_q.delete();
        if ($urandom_range(0, 11) == 0) begin
            // raw noise, often shorter than a timestamp
            n = $urandom_range(1, 60);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_ts();
        if ($urandom_range(0, 2) == 0) add_pick(" FSMx:", $urandom_range(1, 4));
        add_str(" FSM: ");
        add_pick("abid :", $urandom_range(1, 6));
        add_str(" id:");
        add_pick(" ", $urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0:       add_pick("0123456789", 20);
            1:       add_str("18446744073709551615");
            2:       add_str("18446744073709551616");
            3:       add_pick("x1", 3);
            default: add_pick("0123456789", $urandom_range(1, 6));
        endcase
        if ($urandom_range(0, 3) == 0) add_pick("9a ", 2);
        add_str(";");
        add_pick(" ", $urandom_range(0, 2));
        state_line = 1'($urandom_range(0, 1));
        add_str(state_line ? "< St" : "> St");
        case ($urandom_range(0, 4))
            0: ;
            1: add_str(": ");
            2: add_str(":");
            3: begin
                add_pick("0123456789", $urandom_range(1, 3));
                add_str(" ");
            end
            default: add_str(" ");
        endcase
        add_pick("abcXYZ09:", $urandom_range(1, 5));
        if (state_line) begin
            if ($urandom_range(0, 2) != 0) begin
                add_str(" ");
                add_pick("ab (", $urandom_range(0, 5));
            end
        end else begin
            add_str(" ");
            if ($urandom_range(0, 3) == 0) begin
                add_pick("Pxr", $urandom_range(1, 3));
                add_str(" ");
            end
            add_str("Pr:");
            add_pick(" ", $urandom_range(0, 2));
            add_pick("ab:", $urandom_range(1, 4));
            if ($urandom_range(0, 4) != 0) add_str(":");
            add_pick("01", $urandom_range(0, 2));
            if ($urandom_range(0, 5) != 0) begin
                add_str(" ");
                add_pick(" ", $urandom_range(0, 2));
                add_pick("hello w(", $urandom_range(1, 12));
            end
            case ($urandom_range(0, 2))
                0: begin
                    add_str(" (");
                    add_pick("x) ", $urandom_range(0, 4));
                end
                1: add_pick(" ", $urandom_range(1, 3));
                default: ;
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            line_q[$urandom_range(TS_LEN, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, line_q.size());
            while (line_q.size() > n) void'(line_q.pop_back());
        end
    endtask

    task automatic field_diff(string nm, logic [63:0] e, logic [63:0] a);
        $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, nm, e, a);
        errors++;
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && !o_stall;
        out_fire <= i_rst_n && o_valid && !i_stall;
    end

    // sender: per-byte gap before offering, optional wait for the pipe to drain
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (!gap_loaded && byte_q.size() != 0) begin
                gap_left = byte_q[0].gap;
                gap_loaded = 1;
            end
            if (gap_loaded && gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (gap_loaded && !(byte_q[0].pause && parse_out_q.size() != 0)) begin
                cur = byte_q.pop_front();
                gap_loaded = 0;
                i_item  <= cur.it;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall after each result, two long hold-offs
    always @(negedge i_clk) begin
        if (out_fire) begin
            if (res_count % 64 == 0) rmax = ($urandom_range(0, 2) == 0) ? 0 : 12;
            stall_left = $urandom_range(0, rmax);
            if (res_count == HOLD_A || res_count == HOLD_B) stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) parse_byte(i_item);
            if (o_valid && !i_stall) begin
                res_count++;
                if (parse_out_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, o_result);
                    errors++;
                end else begin
                    want = parse_out_q.pop_front();
                    if (o_result.result_kind !== want.result_kind)
                        field_diff("result_kind", want.result_kind, o_result.result_kind);
                    if (o_result.field_tag !== want.field_tag)
                        field_diff("field_tag", want.field_tag, o_result.field_tag);
                    if (o_result.field_byte !== want.field_byte)
                        field_diff("field_byte", want.field_byte, o_result.field_byte);
                    if (o_result.line_type !== want.line_type)
                        field_diff("line_type", want.line_type, o_result.line_type);
                    if (o_result.unit_id !== want.unit_id)
                        field_diff("unit_id", want.unit_id, o_result.unit_id);
                    if (o_result.last_of_run !== want.last_of_run)
                        field_diff("last_of_run", want.last_of_run, o_result.last_of_run);
                    if (want.result_kind == KIND_FIELD) field_count++;
                    else if (want.line_type == LT_MSG) n_msg++;
                    else if (want.line_type == LT_STATE) n_state++;
                    else n_invalid++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, parse_out_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int rand_lines;
        clear_line();

        // extreme byte values on a tiny line, then a single-byte line
        line_q = {8'h00, 8'hFF};
        send_line(0);
        line_q = {8'h5A};
        send_line(0);
        queue_line_text("x FSM: alpha id: 42; > St: 3 idle Pr: a:b hello  world (tail", 0);
        queue_line_text(" FSM: ovf id:18446744073709551616;< St s", 0);
        queue_line_text(" FSM: nm i", 0);
        queue_line_text(" FSM: q id:1;< St", 0);
        queue_line_text(" FSM: q id:1;> St", 1);
        queue_line_text(" FSM: q id:1;> St 12 s Pr:: msg   ", 0);

        rand_lines = 0;
        while (bytes_built < 360) begin
            make_random_line();
            send_line(rand_lines % 9 == 0);
            rand_lines++;
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || gap_loaded || i_valid) @(posedge i_clk);
        while (parse_out_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d lines, %0d bytes, %0d results in %0d cycles",
                 lines_built, bytes_built, res_count, cycles);
        $display("field bytes %0d, verdicts: %0d message, %0d state change, %0d invalid",
                 field_count, n_msg, n_state, n_invalid);
        if (errors == 0 && parse_out_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
